// ===== src/rws_pkg.sv =====
// shared types and constants for the roulette wheel selector
// used by rws_ctrl and roulette_wheel_selector; no dependencies
`timescale 1ns / 1ps

package rws_pkg;

  localparam int POPULATION_SIZE = 256;
  localparam int FITNESS_BITS    = 16;
  localparam int DRAW_BITS       = 16;

  // fixed field widths of the stream payload
  localparam int KIND_W     = 2;
  localparam int FIELD_W    = 16;
  localparam int OUT_IDX_W  = 8;
  localparam int IN_DATA_W  = 2 * FIELD_W;
  localparam int OUT_DATA_W = OUT_IDX_W;

  localparam int IDX_W  = $clog2(POPULATION_SIZE);
  localparam int CNT_W  = IDX_W + 1;
  localparam int SUM_W  = FITNESS_BITS + IDX_W;
  localparam int PROD_W = DRAW_BITS + SUM_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_SELECT = 2'd2
  } rws_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SEARCH,
    ST_RESULT
  } rws_state_e;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_EMPTY = 1'b1
  } rws_status_e;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] idx;
    rws_status_e          status;
  } rws_result_t;

endpackage

// ===== src/rws_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rws_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rws_ctrl.sv =====
// sequencer for table loads and the scaled binary search over cumulative sums
// depends on rws_pkg; drives the cumulative table ram
`timescale 1ns / 1ps

module rws_ctrl
  import rws_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [KIND_W-1:0]   in_kind_i,
  input  logic [FIELD_W-1:0]  in_fitness_i,
  input  logic [FIELD_W-1:0]  in_draw_i,
  input  logic                res_free_i,
  output logic                res_push_o,
  output rws_result_t         res_o,
  output logic                mem_we_o,
  output logic [IDX_W-1:0]    mem_waddr_o,
  output logic [SUM_W-1:0]    mem_wdata_o,
  output logic [IDX_W-1:0]    mem_raddr_o,
  input  logic [SUM_W-1:0]    mem_rdata_i
);

  rws_state_e         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [SUM_W-1:0]   total_q, total_d;
  logic [DRAW_BITS-1:0] draw_q, draw_d;
  logic [SUM_W-1:0]   target_q, target_d;
  logic [IDX_W-1:0]   lo_q, lo_d;
  logic [IDX_W-1:0]   hi_q, hi_d;
  logic [IDX_W-1:0]   mid_q, mid_d;
  rws_result_t        res_q, res_d;

  logic               accept;
  logic               table_empty;
  logic               table_full;
  logic [IDX_W-1:0]   init_hi;
  logic [IDX_W-1:0]   init_mid;
  logic [PROD_W-1:0]  product;
  logic               cum_gt;
  logic [IDX_W-1:0]   step_lo;
  logic [IDX_W-1:0]   step_hi;
  logic [IDX_W:0]     step_sum;
  logic [IDX_W-1:0]   step_mid;
  logic               search_more;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign table_empty = (count_q == '0) || (total_q == '0);
  assign table_full  = (count_q == CNT_W'(POPULATION_SIZE));

  assign init_hi  = IDX_W'(count_q - CNT_W'(1));
  assign init_mid = init_hi >> 1;

  // draw scaled by the total, fraction dropped
  assign product = PROD_W'(draw_q) * PROD_W'(total_q);

  // one halving step per cycle on the entry read last cycle
  assign cum_gt      = (mem_rdata_i > target_q);
  assign step_lo     = cum_gt ? lo_q : IDX_W'(mid_q + IDX_W'(1));
  assign step_hi     = cum_gt ? mid_q : hi_q;
  assign step_sum    = {1'b0, step_lo} + {1'b0, step_hi};
  assign step_mid    = step_sum[IDX_W:1];
  assign search_more = (step_lo < step_hi);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_kind_i == KIND_SELECT)) begin
          state_d = table_empty ? ST_RESULT : ST_SCALE;
        end
      end
      ST_SCALE: begin
        state_d = (init_hi == '0) ? ST_RESULT : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!search_more) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    total_d     = total_q;
    draw_d      = draw_q;
    target_d    = target_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = IDX_W'(count_q);
    mem_wdata_o = SUM_W'(total_q + SUM_W'(in_fitness_i[FITNESS_BITS-1:0]));
    mem_raddr_o = mid_q;
    res_push_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind_i)
            KIND_CLEAR: begin
              count_d = '0;
              total_d = '0;
            end
            KIND_LOAD: begin
              if (!table_full) begin
                mem_we_o = 1'b1;
                total_d  = mem_wdata_o;
                count_d  = CNT_W'(count_q + CNT_W'(1));
              end
            end
            KIND_SELECT: begin
              draw_d = in_draw_i[DRAW_BITS-1:0];
              res_d  = '{idx: '0, status: STATUS_EMPTY};
            end
            default: ;
          endcase
        end
      end
      ST_SCALE: begin
        target_d    = product[PROD_W-1:DRAW_BITS];
        lo_d        = '0;
        hi_d        = init_hi;
        mid_d       = init_mid;
        mem_raddr_o = init_mid;
        res_d       = '{idx: '0, status: STATUS_OK};
      end
      ST_SEARCH: begin
        lo_d        = step_lo;
        hi_d        = step_hi;
        mid_d       = step_mid;
        mem_raddr_o = step_mid;
        res_d       = '{idx: OUT_IDX_W'(step_lo), status: STATUS_OK};
      end
      ST_RESULT: begin
        res_push_o = res_free_i;
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    draw_q   <= draw_d;
    target_q <= target_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    res_q    <= res_d;
  end

endmodule

// ===== src/roulette_wheel_selector.sv =====
// roulette wheel selector: top level with stream ports and output register
// depends on rws_pkg, rws_ctrl and rws_ram
//
// usage:
//   the slave stream carries one command per transaction; tuser holds the
//   kind (clear, load, select), tdata the fitness and the draw
//   a clear empties the table, a load appends one fitness value as a
//   running sum (ignored once the table is full), a select returns one
//   result on the master stream: tdata the chosen index, tuser the status
//   clear and load give no result; the block stays idle after them
//   a select passes through the scale, search and result states: the
//   scale step turns the draw into a target, each halving step of the
//   binary search reads one table entry through the ram read port (no
//   search for a single entry), and the result state pushes the result
//   into the output register; the next command is taken back in idle
//   a select on an empty or zero-total table returns index 0, status 1
//   straight from the result state, with no scale or search step
//   reset empties the table and drops any pending result; ram contents
//   are not cleared and need no clearing pass
//   a stalled receiver holds the result in the output register; the next
//   command is still taken, and a following select waits only when its
//   own result is ready and the register is still occupied
`timescale 1ns / 1ps

module roulette_wheel_selector
  import rws_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // fitness[15:0], draw[31:16]
  input  logic [KIND_W-1:0]     s_axis_tuser_i,   // kind[1:0]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // selected_index[7:0]
  output logic                  m_axis_tuser_o    // status[0]
);

  logic               out_valid_q, out_valid_d;
  rws_result_t        out_q;
  logic               res_free;
  logic               res_push;
  rws_result_t        res;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [SUM_W-1:0]   mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [SUM_W-1:0]   mem_rdata;

  assign res_free = !out_valid_q || m_axis_tready_i;

  rws_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_kind_i    (s_axis_tuser_i),
    .in_fitness_i (s_axis_tdata_i[FIELD_W-1:0]),
    .in_draw_i    (s_axis_tdata_i[IN_DATA_W-1:FIELD_W]),
    .res_free_i   (res_free),
    .res_push_o   (res_push),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  rws_ram #(
    .WIDTH (SUM_W),
    .DEPTH (POPULATION_SIZE)
  ) u_cum_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_push) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.idx;
  assign m_axis_tuser_o  = out_q.status;

endmodule

// ===== tb/roulette_wheel_selector_test.sv =====
// self-checking bench for roulette_wheel_selector: streams clear, load and select
// commands and checks every selection against a table-based predictor
// depends on rws_pkg and the roulette_wheel_selector rtl
`timescale 1ns / 1ps

module roulette_wheel_selector_test;
  import rws_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 375;

  // predictor of the wheel plus the queue of selections still owed by the block
  class selection_scoreboard;
    logic [SUM_W-1:0] running_sums[POPULATION_SIZE];
    logic [CNT_W-1:0] loaded;
    logic [SUM_W-1:0] fitness_total;
    rws_result_t      expected_picks[$];
    int               mismatch_count;

    function new();
      loaded = '0;
      fitness_total = '0;
      mismatch_count = 0;
    endfunction

    function rws_result_t predict_pick(logic [FIELD_W-1:0] draw);
      logic [PROD_W-1:0] product;
      logic [SUM_W-1:0]  target;
      int                lo;
      int                hi;
      int                mid;
      rws_result_t       pick;
      if (loaded == 0 || fitness_total == 0) begin
        pick.idx = '0;
        pick.status = STATUS_EMPTY;
        return pick;
      end
      product = PROD_W'(draw) * PROD_W'(fitness_total);
      target = product[PROD_W-1:DRAW_BITS];
      lo = 0;
      hi = int'(loaded) - 1;
      // first entry whose running sum exceeds the scaled draw
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (running_sums[mid] > target) hi = mid;
        else lo = mid + 1;
      end
      pick.idx = lo[OUT_IDX_W-1:0];
      pick.status = STATUS_OK;
      return pick;
    endfunction

    function void note_command(logic [KIND_W-1:0] kind, logic [IN_DATA_W-1:0] data);
      case (kind)
        KIND_CLEAR: begin
          loaded = '0;
          fitness_total = '0;
        end
        KIND_LOAD: begin
          if (loaded < POPULATION_SIZE) begin
            fitness_total = fitness_total + SUM_W'(data[FIELD_W-1:0]);
            running_sums[loaded] = fitness_total;
            loaded = loaded + CNT_W'(1);
          end
        end
        KIND_SELECT: begin
          expected_picks.insert(expected_picks.size(),
                                predict_pick(data[IN_DATA_W-1:FIELD_W]));
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [OUT_IDX_W-1:0] idx, logic status);
      rws_result_t want;
      if (expected_picks.size() == 0) begin
        $display("%0t: unexpected result idx %0d status %0d", $time, idx, status);
        mismatch_count++;
        return;
      end
      want = expected_picks.pop_front();
      if (idx !== want.idx) begin
        $display("%0t: selected_index expected %0d actual %0d", $time, want.idx, idx);
        mismatch_count++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [KIND_W-1:0]     s_axis_tuser_i = KIND_CLEAR;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;

  selection_scoreboard sb = new();
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  int items_sent = 0;

  roulette_wheel_selector DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // long receiver hold-off, counted here once the stimulus asks for it
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  task automatic send_cmd(input logic [KIND_W-1:0] kind, input logic [FIELD_W-1:0] fitness,
                          input logic [FIELD_W-1:0] draw);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {draw, fitness};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(kind, {draw, fitness});
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  function automatic logic [FIELD_W-1:0] rand_field();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return FIELD_W'($urandom_range(15));
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  // mostly well-formed clear/load/select runs, with some noise mixed in
  task automatic run_sequences(input int target_items, input bit fill_first);
    int stop_at;
    int n_loads;
    int n_picks;
    bit first;
    stop_at = items_sent + target_items;
    first = fill_first;
    while (items_sent < stop_at) begin
      if (first) begin
        send_cmd(KIND_CLEAR, rand_field(), rand_field());
        // overfill so the trailing loads hit a full table
        n_loads = POPULATION_SIZE + $urandom_range(1, 6);
        for (int i = 0; i < n_loads; i++) send_cmd(KIND_LOAD, rand_field(), rand_field());
        for (int i = 0; i < 12; i++) send_cmd(KIND_SELECT, rand_field(), rand_field());
        first = 1'b0;
      end else if ($urandom_range(99) < 8) begin
        if ($urandom_range(1)) send_cmd(KIND_UNUSED, FIELD_W'($urandom), FIELD_W'($urandom));
        else send_cmd(KIND_SELECT, rand_field(), rand_field());
      end else begin
        if ($urandom_range(9) != 0) send_cmd(KIND_CLEAR, rand_field(), rand_field());
        n_loads = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 10);
        n_picks = $urandom_range(1, 8);
        for (int i = 0; i < n_loads; i++) send_cmd(KIND_LOAD, rand_field(), rand_field());
        for (int i = 0; i < n_picks; i++) send_cmd(KIND_SELECT, rand_field(), rand_field());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, zero total, extreme fitness and draws, unused kind
    send_cmd(KIND_SELECT, 16'h0000, 16'h1234);
    send_cmd(KIND_LOAD,   16'h0000, 16'hFFFF);
    send_cmd(KIND_LOAD,   16'h0000, 16'h0000);
    send_cmd(KIND_SELECT, 16'hFFFF, 16'hFFFF);
    send_cmd(KIND_UNUSED, 16'hFFFF, 16'hFFFF);
    send_cmd(KIND_LOAD,   16'hFFFF, 16'h0000);
    send_cmd(KIND_LOAD,   16'h0000, 16'h0000);
    send_cmd(KIND_LOAD,   16'h0001, 16'h0000);
    send_cmd(KIND_SELECT, 16'h0000, 16'h0000);
    send_cmd(KIND_SELECT, 16'h0000, 16'hFFFF);
    send_cmd(KIND_SELECT, 16'h0000, 16'h8000);
    send_cmd(KIND_SELECT, 16'h0000, 16'hFFFE);
    send_cmd(KIND_CLEAR,  16'hFFFF, 16'hFFFF);
    send_cmd(KIND_SELECT, 16'h0000, 16'h8000);
    send_cmd(KIND_LOAD,   16'h0001, 16'h0000);
    send_cmd(KIND_SELECT, 16'h0000, 16'hFFFF);
    send_cmd(KIND_LOAD,   16'hFFFF, 16'h0000);
    send_cmd(KIND_SELECT, 16'h0000, 16'h0001);
    send_cmd(KIND_SELECT, 16'h0000, 16'hFFFF);
    send_cmd(KIND_UNUSED, 16'h0000, 16'h0000);
    send_cmd(KIND_CLEAR,  16'h0000, 16'h0000);

    // no idling, including a full-table run
    run_sequences(ITEMS_PER_PHASE, 1'b1);

    src_idle_pct = 68;
    run_sequences(ITEMS_PER_PHASE, 1'b0);

    // receiver stalls; starts with a long hold-off while selects keep coming
    src_idle_pct = 0;
    sink_stall_pct <= 68;
    hold_go <= 1'b1;
    send_cmd(KIND_CLEAR, rand_field(), rand_field());
    for (int i = 0; i < 20; i++) send_cmd(KIND_LOAD, rand_field(), rand_field());
    for (int i = 0; i < 24; i++) send_cmd(KIND_SELECT, rand_field(), rand_field());
    run_sequences(ITEMS_PER_PHASE, 1'b0);

    src_idle_pct = 38;
    sink_stall_pct <= 38;
    run_sequences(ITEMS_PER_PHASE, 1'b0);

    s_axis_tvalid_i <= 1'b0;
    sink_stall_pct <= 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rws_pkg.sv
src/rws_ram.sv
src/rws_ctrl.sv
src/roulette_wheel_selector.sv
tb/roulette_wheel_selector_test.sv
